### src/cts_pkg.sv
// Shared types, widths and constants for the cosine Taylor-series core.
// Holds the microcode ROM, the divisor table and the pi/180 constant.
// No dependencies.
package cts_pkg;

	localparam int MAX_TERMS = 16;
	localparam int FRAC_BITS = 40;

	localparam int NT_W      = 5;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int ANGLE_W   = 26;
	localparam int X_W       = 44;
	localparam int X2_W      = 48;
	localparam int M_W       = 64;
	localparam int ACC_W     = 112;
	localparam int SUM_W     = 48;
	localparam int QUO_W     = 72;
	localparam int DEN_W     = 10;
	localparam int X_SHIFT   = 78 - FRAC_BITS;
	localparam int DIV_RADIX = 8;
	localparam int DIV_STEPS = QUO_W / DIV_RADIX;
	localparam int DCNT_W    = 4;
	localparam int PC_W      = 5;

	localparam logic [NT_W-1:0]  NUM_TERMS_RST = NT_W'(10);
	localparam logic [SUM_W-1:0] SUM_HALF      = SUM_W'(1) << (SUM_W - 1);
	localparam logic [SUM_W-1:0] SUM_MAX       = '1;
	localparam logic [M_W-1:0]   TERM0         = M_W'(1) << FRAC_BITS;
	localparam logic [DCNT_W-1:0] DIV_LAST     = DCNT_W'(DIV_STEPS - 1);

	// binary fraction num/den with 62 fractional bits, elaboration time only
	function automatic logic [63:0] frac_q62(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] r;
		logic [63:0] q;
		r = num;
		q = '0;
		for (int i = 0; i < 62; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				q[0] = 1'b1;
				r = r - den;
			end
		end
		return q;
	endfunction

	localparam logic [63:0] K_DEG2RAD = frac_q62(64'd3141592653589, 64'd180000000000000);

	// (2k-1)(2k) for term k
	function automatic logic [DEN_W-1:0] den_of(input logic [IDX_W-1:0] k);
		logic [DEN_W-1:0] d;
		case (k)
			4'd1:    d = 10'd2;
			4'd2:    d = 10'd12;
			4'd3:    d = 10'd30;
			4'd4:    d = 10'd56;
			4'd5:    d = 10'd90;
			4'd6:    d = 10'd132;
			4'd7:    d = 10'd182;
			4'd8:    d = 10'd240;
			4'd9:    d = 10'd306;
			4'd10:   d = 10'd380;
			4'd11:   d = 10'd462;
			4'd12:   d = 10'd552;
			4'd13:   d = 10'd650;
			4'd14:   d = 10'd756;
			4'd15:   d = 10'd870;
			default: d = 10'd1;
		endcase
		return d;
	endfunction

	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_IN   = 2'd1,
		HOLD_OUT  = 2'd2,
		HOLD_DIV  = 2'd3
	} hold_t;

	typedef enum logic [1:0] {
		BR_NONE   = 2'd0,
		BR_ALWAYS = 2'd1,
		BR_LAST   = 2'd2
	} br_t;

	typedef enum logic [1:0] {
		A_MAG = 2'd0,
		A_X   = 2'd1,
		A_M   = 2'd2
	} asel_t;

	typedef enum logic [1:0] {
		B_K  = 2'd0,
		B_X  = 2'd1,
		B_X2 = 2'd2
	} bsel_t;

	typedef struct packed {
		hold_t           hold;
		br_t             br;
		logic [PC_W-1:0] target;
		logic            mul_en;
		asel_t           a_sel;
		logic            a_hi;
		bsel_t           b_sel;
		logic            b_hi;
		logic            acc_clr;
		logic            ld_init;
		logic            ld_x;
		logic            ld_x2;
		logic            ld_div;
		logic            div_step;
		logic            ld_m;
		logic            add_term;
		logic            emit;
	} cw_t;

	localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
	localparam logic [PC_W-1:0] PC_TERM = PC_W'(11);

	// microprogram; a multiply's product is registered before it is added into the accumulator
	function automatic cw_t ucode(input logic [PC_W-1:0] pc);
		cw_t cw;
		cw = '0;
		case (pc)
			5'd0: begin
				cw.hold = HOLD_IN; cw.ld_init = 1'b1; cw.acc_clr = 1'b1;
			end
			5'd1: begin
				cw.mul_en = 1'b1; cw.a_sel = A_MAG; cw.b_sel = B_K;
			end
			5'd2: begin
				cw.mul_en = 1'b1; cw.a_sel = A_MAG; cw.b_sel = B_K; cw.b_hi = 1'b1;
			end
			5'd3: begin
			end
			5'd4: begin
				cw.ld_x = 1'b1; cw.acc_clr = 1'b1;
			end
			5'd5: begin
				cw.mul_en = 1'b1; cw.a_sel = A_X; cw.b_sel = B_X;
			end
			5'd6: begin
				cw.mul_en = 1'b1; cw.a_sel = A_X; cw.b_sel = B_X; cw.b_hi = 1'b1;
			end
			5'd7: begin
				cw.mul_en = 1'b1; cw.a_sel = A_X; cw.a_hi = 1'b1; cw.b_sel = B_X;
			end
			5'd8: begin
				cw.mul_en = 1'b1; cw.a_sel = A_X; cw.a_hi = 1'b1;
				cw.b_sel = B_X; cw.b_hi = 1'b1;
			end
			5'd9: begin
			end
			5'd10: begin
				cw.ld_x2 = 1'b1; cw.acc_clr = 1'b1;
			end
			5'd11: begin
				cw.add_term = 1'b1;
			end
			5'd12: begin
				cw.hold = HOLD_OUT; cw.emit = 1'b1; cw.br = BR_LAST; cw.target = PC_IDLE;
			end
			5'd13: begin
				cw.mul_en = 1'b1; cw.a_sel = A_M; cw.b_sel = B_X2;
			end
			5'd14: begin
				cw.mul_en = 1'b1; cw.a_sel = A_M; cw.b_sel = B_X2; cw.b_hi = 1'b1;
			end
			5'd15: begin
				cw.mul_en = 1'b1; cw.a_sel = A_M; cw.a_hi = 1'b1; cw.b_sel = B_X2;
			end
			5'd16: begin
				cw.mul_en = 1'b1; cw.a_sel = A_M; cw.a_hi = 1'b1;
				cw.b_sel = B_X2; cw.b_hi = 1'b1;
			end
			5'd17: begin
			end
			5'd18: begin
				cw.ld_div = 1'b1; cw.acc_clr = 1'b1;
			end
			5'd19: begin
				cw.hold = HOLD_DIV; cw.div_step = 1'b1;
			end
			5'd20: begin
				cw.ld_m = 1'b1; cw.br = BR_ALWAYS; cw.target = PC_TERM;
			end
			default: begin
				cw.br = BR_ALWAYS; cw.target = PC_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

### src/cosine_taylor_series_core.sv
// Cosine by Maclaurin series: microcoded sequencer around one 32x32 multiplier,
// a 112-bit accumulator and an 8-bit-per-cycle divider.
// Depends on cts_pkg.
//
// Usage:
//   in channel  (in_valid/in_ready, angle_deg): one angle in degrees, Q.16.
//   out channel (out_valid/out_ready, term_index, partial_sum, last): one
//   transaction per series term, partial_sum in Q8.40, last on the final one.
//   cfg channel (cfg_valid/cfg_ready, cfg_data): number of terms, 0 acts as 1,
//   above 16 acts as 16; always ready, write only while idle.
// Sequence: after the input transaction the angle is scaled by pi/180 and
//   squared before the first partial sum is registered; every later term
//   takes four partial products on the shared multiplier, then nine divider
//   steps of 8 quotient bits. An angle occupies the block until its last term
//   is in the output register, including any output stall; in_ready is high only between angles.
// Stall: a partial sum waits in the output register; the sequencer holds at
//   its emit step until that register is free, so nothing is dropped.
// Reset: control clears, term count returns to 10, block is idle at once.
module cosine_taylor_series_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [cts_pkg::ANGLE_W-1:0]   angle_deg,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [cts_pkg::IDX_W-1:0]     term_index,
	output logic signed [cts_pkg::SUM_W-1:0]     partial_sum,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [cts_pkg::NT_W-1:0]      cfg_data
);

	cts_pkg::cw_t                   cw;
	logic [cts_pkg::PC_W-1:0]       pc_q;
	logic [cts_pkg::NT_W-1:0]       num_terms_q;
	logic [cts_pkg::NT_W-1:0]       n_eff;
	logic [cts_pkg::NT_W-1:0]       n_m1;
	logic                           fire;
	logic                           last_term;
	logic                           take_br;

	logic [cts_pkg::ANGLE_W-1:0]    raw;
	logic [cts_pkg::ANGLE_W-1:0]    mag;
	logic [cts_pkg::ANGLE_W-1:0]    mag_q;
	logic [cts_pkg::X_W-1:0]        x_q;
	logic [cts_pkg::X2_W-1:0]       x2_q;
	logic [cts_pkg::M_W-1:0]        m_q;
	logic [cts_pkg::SUM_W-1:0]      s_q;
	logic [cts_pkg::IDX_W-1:0]      k_q;

	logic [63:0]                    a_word;
	logic [63:0]                    b_word;
	logic [31:0]                    a_part;
	logic [31:0]                    b_part;
	logic [63:0]                    p_s1;
	logic [1:0]                     psh_s1;
	logic                           pv_s1;
	logic [cts_pkg::ACC_W-1:0]      addend;
	logic [cts_pkg::ACC_W-1:0]      acc_q;

	logic [cts_pkg::QUO_W-1:0]      div_q;
	logic [cts_pkg::DEN_W-1:0]      rem_q;
	logic [cts_pkg::DCNT_W-1:0]     dcnt_q;
	logic [cts_pkg::DEN_W-1:0]      den;
	logic [cts_pkg::DEN_W-1:0]      rem_nx;
	logic [cts_pkg::DIV_RADIX-1:0]  qbits;

	logic [cts_pkg::SUM_W-1:0]      headroom;
	logic [cts_pkg::SUM_W-1:0]      sum_nx;

	logic                           out_valid_q;
	logic [cts_pkg::IDX_W-1:0]      term_index_q;
	logic [cts_pkg::SUM_W-1:0]      partial_sum_q;
	logic                           last_q;

	assign cw = cts_pkg::ucode(pc_q);

	// effective term count and end-of-angle test
	always_comb begin
		if (num_terms_q == '0)
			n_eff = cts_pkg::NT_W'(1);
		else if (num_terms_q > cts_pkg::NT_W'(cts_pkg::MAX_TERMS))
			n_eff = cts_pkg::NT_W'(cts_pkg::MAX_TERMS);
		else
			n_eff = num_terms_q;
	end
	assign n_m1      = n_eff - cts_pkg::NT_W'(1);
	assign last_term = ({1'b0, k_q} == n_m1);

	always_comb begin
		case (cw.hold)
			cts_pkg::HOLD_NONE: fire = 1'b1;
			cts_pkg::HOLD_IN:   fire = in_valid;
			cts_pkg::HOLD_OUT:  fire = !out_valid_q || out_ready;
			cts_pkg::HOLD_DIV:  fire = (dcnt_q == cts_pkg::DIV_LAST);
			default:            fire = 1'b1;
		endcase
	end

	always_comb begin
		case (cw.br)
			cts_pkg::BR_NONE:   take_br = 1'b0;
			cts_pkg::BR_ALWAYS: take_br = 1'b1;
			cts_pkg::BR_LAST:   take_br = last_term;
			default:            take_br = 1'b0;
		endcase
	end

	assign in_ready  = (cw.hold == cts_pkg::HOLD_IN);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= cts_pkg::PC_IDLE;
			num_terms_q <= cts_pkg::NUM_TERMS_RST;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (cfg_valid)
				num_terms_q <= cfg_data;
			if (fire)
				pc_q <= take_br ? cw.target : pc_q + cts_pkg::PC_W'(1);
			pv_s1 <= cw.mul_en;
			if (cw.ld_init && fire)
				k_q <= '0;
			else if (cw.emit && fire && !last_term)
				k_q <= k_q + cts_pkg::IDX_W'(1);
			if (cw.emit && fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// magnitude of the angle; cosine is even
	assign raw = angle_deg;
	assign mag = angle_deg[cts_pkg::ANGLE_W-1] ? (~raw + cts_pkg::ANGLE_W'(1)) : raw;

	// shared 32x32 multiplier
	always_comb begin
		case (cw.a_sel)
			cts_pkg::A_MAG: a_word = 64'(mag_q);
			cts_pkg::A_X:   a_word = 64'(x_q);
			cts_pkg::A_M:   a_word = m_q;
			default:        a_word = '0;
		endcase
		case (cw.b_sel)
			cts_pkg::B_K:  b_word = cts_pkg::K_DEG2RAD;
			cts_pkg::B_X:  b_word = 64'(x_q);
			cts_pkg::B_X2: b_word = 64'(x2_q);
			default:       b_word = '0;
		endcase
	end
	assign a_part = cw.a_hi ? a_word[63:32] : a_word[31:0];
	assign b_part = cw.b_hi ? b_word[63:32] : b_word[31:0];

	always_comb begin
		case (psh_s1)
			2'd0:    addend = cts_pkg::ACC_W'(p_s1);
			2'd1:    addend = cts_pkg::ACC_W'({p_s1, 32'b0});
			2'd2:    addend = cts_pkg::ACC_W'({p_s1, 64'b0});
			default: addend = '0;
		endcase
	end

	// divider: eight restoring steps per cycle, MSB first
	assign den = cts_pkg::den_of(k_q);
	always_comb begin
		logic [cts_pkg::DEN_W-1:0] r;
		logic [cts_pkg::DEN_W:0]   cur;
		r     = rem_q;
		qbits = '0;
		for (int i = cts_pkg::DIV_RADIX - 1; i >= 0; i--) begin
			cur = {r, div_q[cts_pkg::QUO_W - cts_pkg::DIV_RADIX + i]};
			if (cur >= {1'b0, den}) begin
				qbits[i] = 1'b1;
				r        = cts_pkg::DEN_W'(cur - {1'b0, den});
			end else begin
				r = cur[cts_pkg::DEN_W-1:0];
			end
		end
		rem_nx = r;
	end

	// saturating update of the offset sum (offset 128.0)
	assign headroom = cts_pkg::SUM_MAX - s_q;
	always_comb begin
		if (!k_q[0]) begin
			if (m_q > cts_pkg::M_W'(headroom))
				sum_nx = cts_pkg::SUM_MAX;
			else
				sum_nx = s_q + m_q[cts_pkg::SUM_W-1:0];
		end else begin
			if (m_q > cts_pkg::M_W'(s_q))
				sum_nx = '0;
			else
				sum_nx = s_q - m_q[cts_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= a_part * b_part;
		psh_s1 <= 2'(cw.a_hi) + 2'(cw.b_hi);
		if (cw.acc_clr && fire)
			acc_q <= '0;
		else if (pv_s1)
			acc_q <= acc_q + addend;
		if (cw.ld_init && fire) begin
			mag_q <= mag;
			m_q   <= cts_pkg::TERM0;
			s_q   <= cts_pkg::SUM_HALF;
		end
		if (cw.ld_x)
			x_q <= acc_q[cts_pkg::X_SHIFT +: cts_pkg::X_W];
		if (cw.ld_x2)
			x2_q <= acc_q[cts_pkg::FRAC_BITS +: cts_pkg::X2_W];
		if (cw.ld_div) begin
			div_q  <= acc_q[cts_pkg::FRAC_BITS +: cts_pkg::QUO_W];
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cw.div_step) begin
			div_q  <= {div_q[cts_pkg::QUO_W-cts_pkg::DIV_RADIX-1:0], qbits};
			rem_q  <= rem_nx;
			dcnt_q <= dcnt_q + cts_pkg::DCNT_W'(1);
		end
		// quotient above 64 bits saturates the term
		if (cw.ld_m)
			m_q <= (|div_q[cts_pkg::QUO_W-1:cts_pkg::M_W]) ? '1 : div_q[cts_pkg::M_W-1:0];
		if (cw.add_term)
			s_q <= sum_nx;
		if (cw.emit && fire) begin
			term_index_q  <= k_q;
			partial_sum_q <= {~s_q[cts_pkg::SUM_W-1], s_q[cts_pkg::SUM_W-2:0]};
			last_q        <= last_term;
		end
	end

	assign out_valid   = out_valid_q;
	assign term_index  = term_index_q;
	assign partial_sum = partial_sum_q;
	assign last        = last_q;

endmodule

### src/cts_checker.sv
// Port-level checks for the cosine Taylor-series core, bound to the top level.
// Depends on cts_pkg.
module cts_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic signed [cts_pkg::ANGLE_W-1:0]   angle_deg,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic        [cts_pkg::IDX_W-1:0]     term_index,
	input logic signed [cts_pkg::SUM_W-1:0]     partial_sum,
	input logic                                 last
);

	logic [cts_pkg::IDX_W-1:0] exp_idx_q;

	// term index expected on the next output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_idx_q <= '0;
		else if (out_valid && out_ready)
			exp_idx_q <= last ? '0 : term_index + cts_pkg::IDX_W'(1);
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(angle_deg))
		else $error("input changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(partial_sum)
			&& $stable(term_index) && $stable(last))
		else $error("output changed while stalled");

	a_idx_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> term_index == exp_idx_q)
		else $error("term index out of sequence");

	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken before the series finished");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input transaction");

endmodule

bind cosine_taylor_series_core cts_checker u_cts_checker (.*);
